>>> rtl/core/fxq_pkg.sv
// ----------------------------------------------------------------------------
// fxq_pkg
// Shared types, opcodes and constants of the Q24.8 fixed-point ALU core.
// ----------------------------------------------------------------------------
package fxq_pkg;

   localparam int FRACTION_BITS_DEF = 8;
   localparam int FRACTION_BITS_MAX = 30;
   // widest divider numerator: 32 magnitude bits plus the fraction shift
   localparam int QS_W              = 32 + FRACTION_BITS_MAX;
   // quotient bits resolved by one divider stage
   localparam int DIV_STEPS         = 4;

   typedef enum logic [3:0] {
      OP_ADD     = 4'd0,
      OP_SUB     = 4'd1,
      OP_MUL     = 4'd2,
      OP_DIV     = 4'd3,
      OP_LT      = 4'd4,
      OP_GT      = 4'd5,
      OP_LE      = 4'd6,
      OP_GE      = 4'd7,
      OP_EQ      = 4'd8,
      OP_NE      = 4'd9,
      OP_MIN     = 4'd10,
      OP_MAX     = 4'd11,
      OP_INC     = 4'd12,
      OP_DEC     = 4'd13,
      OP_TOINT   = 4'd14,
      OP_FROMINT = 4'd15
   } op_type;

   typedef struct packed {
      logic [3:0]         cmd;
      logic signed [31:0] operand_a;
      logic signed [31:0] operand_b;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_value;
      logic               compare_true;
      logic               divide_by_zero;
      logic               overflow;
   } rsp_type;

   // item state carried down the pipeline
   typedef struct packed {
      op_type             op;
      logic [31:0]        simp_res;
      logic               simp_cmp;
      logic               simp_ovf;
      logic signed [63:0] prod;
      logic [QS_W-1:0]    qs;
      logic [31:0]        rem;
      logic [31:0]        den;
      logic               neg;
      logic               dz;
   } pipe_type;

endpackage

>>> rtl/core/fxq_front.sv
// ----------------------------------------------------------------------------
// fxq_front
// Decode stage: simple operations, full product, divider setup.
// ----------------------------------------------------------------------------
module fxq_front #(
   parameter int FRACTION_BITS = fxq_pkg::FRACTION_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  fxq_pkg::req_type in_data,
   output logic             in_ready,
   output logic             out_valid,
   output fxq_pkg::pipe_type out_data,
   input  logic             out_ready
);

   logic               valid_ff;
   fxq_pkg::pipe_type  data_ff;
   fxq_pkg::pipe_type  data_in;
   logic signed [31:0] a;
   logic signed [31:0] b;
   logic [32:0]        sum;
   logic signed [63:0] wide;
   logic [31:0]        mag_a;
   logic [31:0]        mag_b;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;
   assign a = in_data.operand_a;
   assign b = in_data.operand_b;

   always_comb begin
      mag_a = a[31] ? (32'd0 - a) : a;
      mag_b = b[31] ? (32'd0 - b) : b;
      sum   = 33'd0;
      wide  = 64'sd0;
      data_in          = '0;
      data_in.op       = fxq_pkg::op_type'(in_data.cmd);
      data_in.prod     = 64'(a) * 64'(b);
      data_in.qs       = fxq_pkg::QS_W'(mag_a) << FRACTION_BITS;
      data_in.rem      = 32'd0;
      data_in.den      = mag_b;
      data_in.neg      = a[31] ^ b[31];
      data_in.dz       = (b == 32'sd0);
      unique case (fxq_pkg::op_type'(in_data.cmd)) inside
         fxq_pkg::OP_ADD, fxq_pkg::OP_SUB, fxq_pkg::OP_INC, fxq_pkg::OP_DEC: begin
            unique case (fxq_pkg::op_type'(in_data.cmd))
               fxq_pkg::OP_ADD: sum = {a[31], a} + {b[31], b};
               fxq_pkg::OP_SUB: sum = {a[31], a} - {b[31], b};
               fxq_pkg::OP_INC: sum = {a[31], a} + 33'd1;
               default:         sum = {a[31], a} - 33'd1;
            endcase
            data_in.simp_res = sum[31:0];
            data_in.simp_ovf = sum[32] ^ sum[31];
         end
         fxq_pkg::OP_LT: data_in.simp_cmp = (a <  b);
         fxq_pkg::OP_GT: data_in.simp_cmp = (a >  b);
         fxq_pkg::OP_LE: data_in.simp_cmp = (a <= b);
         fxq_pkg::OP_GE: data_in.simp_cmp = (a >= b);
         fxq_pkg::OP_EQ: data_in.simp_cmp = (a == b);
         fxq_pkg::OP_NE: data_in.simp_cmp = (a != b);
         fxq_pkg::OP_MIN: data_in.simp_res = (a > b) ? b : a;
         fxq_pkg::OP_MAX: data_in.simp_res = (a > b) ? a : b;
         fxq_pkg::OP_TOINT: data_in.simp_res = a >>> FRACTION_BITS;
         fxq_pkg::OP_FROMINT: begin
            wide = 64'(a) <<< FRACTION_BITS;
            data_in.simp_res = wide[31:0];
            data_in.simp_ovf = !((&wide[63:31]) || !(|wide[63:31]));
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

>>> rtl/core/fxq_div_stage.sv
// ----------------------------------------------------------------------------
// fxq_div_stage
// One stage of the restoring divider: resolves up to four quotient bits.
// ----------------------------------------------------------------------------
module fxq_div_stage #(
   parameter int NUM_W      = 40,
   parameter int FIRST_STEP = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  fxq_pkg::pipe_type in_data,
   output logic              in_ready,
   output logic              out_valid,
   output fxq_pkg::pipe_type out_data,
   input  logic              out_ready
);

   logic              valid_ff;
   fxq_pkg::pipe_type data_ff;
   fxq_pkg::pipe_type data_in;
   logic [32:0]       part;
   logic              ge;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      data_in = in_data;
      part    = 33'd0;
      ge      = 1'b0;
      for (int k = 0; k < fxq_pkg::DIV_STEPS; k++) begin
         if (FIRST_STEP + k < NUM_W) begin
            part = {data_in.rem, data_in.qs[NUM_W-1]};
            ge   = (part >= {1'b0, data_in.den});
            if (ge) begin
               part = part - {1'b0, data_in.den};
            end
            data_in.rem = part[31:0];
            data_in.qs  = {data_in.qs[fxq_pkg::QS_W-2:0], ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

>>> rtl/core/fxq_back.sv
// ----------------------------------------------------------------------------
// fxq_back
// Final stage: rounds product and quotient, applies sign, flags overflow and divide by zero.
// ----------------------------------------------------------------------------
module fxq_back #(
   parameter int FRACTION_BITS = fxq_pkg::FRACTION_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  fxq_pkg::pipe_type in_data,
   output logic              in_ready,
   output logic              out_valid,
   output fxq_pkg::rsp_type  out_data,
   input  logic              out_ready
);

   localparam int NUM_W = 32 + FRACTION_BITS;
   localparam logic signed [63:0] HALF = 64'sd1 <<< (FRACTION_BITS - 1);

   logic             valid_ff;
   fxq_pkg::rsp_type data_ff;
   fxq_pkg::rsp_type data_in;
   logic signed [63:0] adj;
   logic signed [63:0] r;
   logic [63:0]        m;
   logic               rnd;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      data_in = '0;
      adj = 64'sd0;
      r   = 64'sd0;
      m   = 64'(in_data.qs[NUM_W-1:0]);
      rnd = ({in_data.rem, 1'b0} >= {1'b0, in_data.den});
      unique case (in_data.op)
         fxq_pkg::OP_MUL: begin
            // ties away from zero: negative products round on (p + half - 1)
            adj = in_data.prod + HALF - 64'(in_data.prod[63]);
            r   = adj >>> FRACTION_BITS;
            data_in.result_value = r[31:0];
            data_in.overflow     = !((&r[63:31]) || !(|r[63:31]));
         end
         fxq_pkg::OP_DIV: begin
            if (in_data.dz) begin
               data_in.divide_by_zero = 1'b1;
            end else begin
               r = in_data.neg ? signed'(~m + 64'(!rnd)) : signed'(m + 64'(rnd));
               data_in.result_value = r[31:0];
               data_in.overflow     = !((&r[63:31]) || !(|r[63:31]));
            end
         end
         default: begin
            data_in.result_value = in_data.simp_res;
            data_in.compare_true = in_data.simp_cmp;
            data_in.overflow     = in_data.simp_ovf;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

>>> rtl/core/fixed_point_q24_8_alu_core.sv
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu_core
// Pipelined signed Q24.8 fixed-point ALU.
// ----------------------------------------------------------------------------
// Accepts one beat per cycle while req_stall is low and returns one result beat
// per item, in order. Every operation passes through the front stage, the
// divider stages and the back stage; the divider stages belong to the
// restoring divider, which resolves four quotient bits per stage, and all
// operations share that pipeline. Stall on the result side fills empty stages
// before it holds off new beats.
module fixed_point_q24_8_alu_core #(
   parameter int FRACTION_BITS = fxq_pkg::FRACTION_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  fxq_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output fxq_pkg::rsp_type rsp_payload
);

   localparam int NUM_W = 32 + FRACTION_BITS;
   localparam int NDIV  = (NUM_W + fxq_pkg::DIV_STEPS - 1) / fxq_pkg::DIV_STEPS;

   fxq_pkg::pipe_type stg_data  [0:NDIV];
   logic              stg_valid [0:NDIV];
   logic              stg_ready [0:NDIV];
   logic              front_ready;

   assign req_stall = !front_ready;

   fxq_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_data   (req_payload),
      .in_ready  (front_ready),
      .out_valid (stg_valid[0]),
      .out_data  (stg_data[0]),
      .out_ready (stg_ready[0])
   );

   for (genvar s = 0; s < NDIV; s++) begin : g_div
      fxq_div_stage #(
         .NUM_W      (NUM_W),
         .FIRST_STEP (s * fxq_pkg::DIV_STEPS)
      ) u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stg_valid[s]),
         .in_data   (stg_data[s]),
         .in_ready  (stg_ready[s]),
         .out_valid (stg_valid[s+1]),
         .out_data  (stg_data[s+1]),
         .out_ready (stg_ready[s+1])
      );
   end

   fxq_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stg_valid[NDIV]),
      .in_data   (stg_data[NDIV]),
      .in_ready  (stg_ready[NDIV]),
      .out_valid (rsp_valid),
      .out_data  (rsp_payload),
      .out_ready (!rsp_stall)
   );

endmodule

>>> rtl/core/fxq_checker.sv
// ----------------------------------------------------------------------------
// fxq_checker
// Port-level checks on the ALU core result channel.
// ----------------------------------------------------------------------------
module fxq_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input fxq_pkg::rsp_type rsp_payload
);

   // hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_payload))
      else $error("stalled result payload changed");

   a_dz_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.divide_by_zero |->
         rsp_payload.result_value == 32'sd0 && !rsp_payload.overflow
         && !rsp_payload.compare_true)
      else $error("zero-divisor beat carries data or flags");

   a_cmp_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.compare_true |->
         rsp_payload.result_value == 32'sd0 && !rsp_payload.overflow)
      else $error("compare beat carries a value or overflow");

   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind fixed_point_q24_8_alu_core fxq_checker u_fxq_checker (.*);
